// ===== sv/sitda_pkg.sv =====
`default_nettype none

package sitda_pkg;

   // Default sizes of the converter.
   localparam int DATA_WIDTH_DEF = 32;
   localparam int MAX_CHARS_DEF  = 11;

   // Magnitude bits folded into the BCD register per cycle.
   localparam int BITS_PER_STEP = 4;

   // ASCII codes.
   localparam logic [7:0] CHR_ZERO  = 8'd48;
   localparam logic [7:0] CHR_MINUS = 8'd45;

   // Shift-and-add-3 correction: a BCD digit of five or more gets three added.
   localparam logic [3:0] BCD_ADJ_LIMIT = 4'd5;
   localparam logic [3:0] BCD_ADJ       = 4'd3;

   // Decimal digits needed for an unsigned value of the given width
   // (0.30103 approximates log10(2); the estimate is never short).
   function automatic int num_digits(input int width);
      return (width * 30103) / 100000 + 1;
   endfunction

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_PREP,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic prep;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic conv_last;
      logic out_free;
      logic final_char;
   } status_type;

endpackage

`default_nettype wire

// ===== sv/sitda_ctrl.sv =====
`default_nettype none

module sitda_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire sitda_pkg::status_type status,
   output sitda_pkg::cmd_type         cmd
);

   sitda_pkg::state_type state_ff;
   sitda_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sitda_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         sitda_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = sitda_pkg::ST_CONV;
            end
         end
         sitda_pkg::ST_CONV: begin
            cmd.step = 1'b1;
            if (status.conv_last) begin
               state_in = sitda_pkg::ST_PREP;
            end
         end
         sitda_pkg::ST_PREP: begin
            cmd.prep = 1'b1;
            state_in = sitda_pkg::ST_EMIT;
         end
         sitda_pkg::ST_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.final_char) begin
                  state_in = sitda_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = sitda_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== sv/sitda_datapath.sv =====
`default_nettype none

module sitda_datapath #(
   parameter int DATA_WIDTH = sitda_pkg::DATA_WIDTH_DEF,
   parameter int MAX_CHARS  = sitda_pkg::MAX_CHARS_DEF
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire sitda_pkg::cmd_type      cmd,
   output sitda_pkg::status_type        status,
   input  wire logic [DATA_WIDTH-1:0]   number_in,
   input  wire logic                    rsp_stall,
   output logic                         rsp_valid,
   output logic [7:0]                   rsp_ascii_char,
   output logic                         rsp_last_char
);

   localparam int BPS    = sitda_pkg::BITS_PER_STEP;
   localparam int STEPS  = (DATA_WIDTH + BPS - 1) / BPS;
   localparam int PAD_W  = STEPS * BPS;
   localparam int NDIG   = sitda_pkg::num_digits(DATA_WIDTH);
   localparam int BCD_W  = NDIG * 4;
   localparam int PTR_W  = $clog2(NDIG);
   localparam int STEP_W = (STEPS > 1) ? $clog2(STEPS) : 1;
   localparam int MAXC   = (NDIG + 1 > MAX_CHARS) ? NDIG + 1 : MAX_CHARS;
   localparam int CNT_W  = $clog2(MAXC + 1);

   logic [PAD_W-1:0]      mag_ff;
   logic [BCD_W-1:0]      bcd_ff;
   logic                  neg_ff;
   logic [STEP_W-1:0]     step_ff;
   logic [PTR_W-1:0]      ptr_ff;
   logic [CNT_W-1:0]      rem_ff;
   logic                  sign_pend_ff;
   logic                  rsp_valid_ff;
   logic [7:0]            rsp_char_ff;
   logic                  rsp_last_ff;

   logic [DATA_WIDTH-1:0] mag_abs;
   logic [BCD_W-1:0]      bcd_work;
   logic [3:0]            digit_arr [NDIG];
   logic [PTR_W-1:0]      top_idx;
   logic [CNT_W-1:0]      total;
   logic [CNT_W-1:0]      count;
   logic [7:0]            char_sel;

   // The magnitude is taken as unsigned, so the most negative value works.
   assign mag_abs = number_in[DATA_WIDTH-1] ? DATA_WIDTH'(~number_in + 1'b1) : number_in;

   // Shift-and-add-3 over BPS magnitude bits.
   always_comb begin
      bcd_work = bcd_ff;
      for (int b = 0; b < BPS; b++) begin
         for (int d = 0; d < NDIG; d++) begin
            if (bcd_work[d*4 +: 4] >= sitda_pkg::BCD_ADJ_LIMIT) begin
               bcd_work[d*4 +: 4] = bcd_work[d*4 +: 4] + sitda_pkg::BCD_ADJ;
            end
         end
         bcd_work = {bcd_work[BCD_W-2:0], mag_ff[PAD_W-1-b]};
      end
   end

   // Highest nonzero digit; digit zero always prints.
   always_comb begin
      top_idx = '0;
      for (int d = 0; d < NDIG; d++) begin
         digit_arr[d] = bcd_ff[d*4 +: 4];
      end
      for (int d = 1; d < NDIG; d++) begin
         if (bcd_ff[d*4 +: 4] != 4'd0) begin
            top_idx = PTR_W'(d);
         end
      end
      total = CNT_W'(top_idx) + CNT_W'(1) + CNT_W'(neg_ff);
      count = (total > CNT_W'(MAX_CHARS)) ? CNT_W'(MAX_CHARS) : total;
   end

   assign char_sel = sign_pend_ff ? sitda_pkg::CHR_MINUS
                                  : sitda_pkg::CHR_ZERO + {4'd0, digit_arr[ptr_ff]};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mag_ff  <= PAD_W'(mag_abs);
         bcd_ff  <= '0;
         neg_ff  <= number_in[DATA_WIDTH-1];
         step_ff <= '0;
      end
      if (cmd.step) begin
         mag_ff  <= mag_ff << BPS;
         bcd_ff  <= bcd_work;
         step_ff <= step_ff + 1'b1;
      end
      if (cmd.prep) begin
         ptr_ff       <= top_idx;
         rem_ff       <= count;
         sign_pend_ff <= neg_ff;
      end
      if (cmd.emit) begin
         rem_ff      <= rem_ff - 1'b1;
         rsp_char_ff <= char_sel;
         rsp_last_ff <= (rem_ff == CNT_W'(1));
         if (sign_pend_ff) begin
            sign_pend_ff <= 1'b0;
         end else begin
            ptr_ff <= ptr_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.conv_last  = (step_ff == STEP_W'(STEPS - 1));
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;
   assign status.final_char = (rem_ff == CNT_W'(1));

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ascii_char = rsp_char_ff;
   assign rsp_last_char  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== sv/signed_int_to_decimal_ascii.sv =====
// A number accepted in idle runs through STEPS = ceil(DATA_WIDTH / 4) steps of the
// shift-and-add-3 BCD converter, then a preparation state and the emit state.
// A new number is taken only after the previous one has written its final character
// into the output register; characters leave one per cycle while rsp_stall is low.
// Reset (synchronous, active high) returns the controller to idle and empties
// the output register; the datapath holds no state that reset must clear.
`default_nettype none

module signed_int_to_decimal_ascii #(
   parameter int DATA_WIDTH = sitda_pkg::DATA_WIDTH_DEF,
   parameter int MAX_CHARS  = sitda_pkg::MAX_CHARS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire logic [DATA_WIDTH-1:0] req_number_in,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output logic [7:0]                 rsp_ascii_char,
   output logic                       rsp_last_char
);

   // The controller sequences each item through four phases: accept, a run
   // of BCD conversion steps, a preparation state that finds the leading digit and
   // the character count, and the emit phase that writes one character into the
   // output register each cycle that register is free.
   sitda_pkg::cmd_type    cmd;
   sitda_pkg::status_type status;

   sitda_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the magnitude, the BCD digits, the digit pointer and
   // the output register. The final character of an item may still wait in
   // the output register while the next item is accepted.
   sitda_datapath #(
      .DATA_WIDTH (DATA_WIDTH),
      .MAX_CHARS  (MAX_CHARS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .number_in      (req_number_in),
      .rsp_stall      (rsp_stall),
      .rsp_valid      (rsp_valid),
      .rsp_ascii_char (rsp_ascii_char),
      .rsp_last_char  (rsp_last_char)
   );

   // A new item may only come in while the pending character, if any, is
   // the final one of the previous item.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && rsp_valid) |-> rsp_last_char)
      else $error("item accepted while a non-final character is pending");

   // After an item is taken, the converter is busy for the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("converter not busy after accepting an item");

   // A minus sign is always followed by at least one digit.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ascii_char == sitda_pkg::CHR_MINUS) |-> !rsp_last_char)
      else $error("minus sign marked as final character");

endmodule

`default_nettype wire
